// ----- hw/rtl/gtp_pkg.sv -----
// ----------------------------------------------------------------------------
// gtp_pkg
// shared types and constants for the glyph tile placement block
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam int SCREEN_W_DEF = 240;
	localparam int SCREEN_H_DEF = 160;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] CODE_RIGHT_QUOTE = 8'd146;
	localparam logic [7:0] CODE_APOSTROPHE  = 8'd39;
	localparam logic [7:0] CODE_UNDERSCORE  = 8'd95;
	localparam logic [7:0] CODE_SPACE       = 8'd32;
	localparam logic [7:0] CODE_LOWER_A     = 8'd97;
	localparam logic [7:0] CODE_LOWER_Z     = 8'd122;
	localparam logic [7:0] CASE_OFFSET      = 8'd32;
	localparam logic [4:0] NARROW_WIDTH     = 5'd8;

	typedef enum logic [1:0] {
		REG_VRAM_BASE  = 2'd0,
		REG_GLYPH_BASE = 2'd1,
		REG_ROW_STRIDE = 2'd2,
		REG_HALF_LINE  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_UPPER_LEFT  = 2'd0,
		CMD_LOWER_LEFT  = 2'd1,
		CMD_UPPER_RIGHT = 2'd2,
		CMD_LOWER_RIGHT = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              half;
		logic              wide;
		logic signed [8:0] col;
		logic [2:0]        sub;
		logic [12:0]       row_prod;
		logic [7:0]        idx;
	} entry_t;

	typedef struct packed {
		cmd_t step;
		logic pop;
	} back_status_t;

endpackage

// ----- hw/rtl/gtp_front.sv -----
// ----------------------------------------------------------------------------
// gtp_front
// clips and normalises a placement and builds the queue entry for it
// ----------------------------------------------------------------------------
module gtp_front #(
	parameter int SCREEN_W = gtp_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = gtp_pkg::SCREEN_H_DEF
) (
	input  logic               accept,
	input  logic [7:0]         char_code,
	input  logic signed [10:0] x_pos,
	input  logic signed [10:0] y_pos,
	input  logic [4:0]         glyph_width,
	input  logic [5:0]         row_stride,
	input  logic               half_line_mode,
	output logic               push,
	output gtp_pkg::entry_t    entry
);

	localparam logic signed [12:0] X_MAX = 13'(SCREEN_W - 1);
	localparam logic signed [12:0] Y_MAX = 13'(SCREEN_H - 1);
	localparam logic signed [12:0] X_MIN = -13'sd16;

	logic signed [12:0] x_ext;
	logic signed [12:0] y_ext;
	logic               clipped;
	logic [7:0]         ch_q1;
	logic [7:0]         ch_norm;
	logic               skipped;
	logic signed [11:0] x_even;
	logic signed [12:0] right_edge;
	logic               off_left;

	assign x_ext   = 13'(x_pos);
	assign y_ext   = 13'(y_pos);
	assign clipped = (x_ext > X_MAX) || (y_ext > Y_MAX) || (y_ext < 13'sd0) ||
		(x_ext <= X_MIN);

	assign ch_q1   = (char_code == gtp_pkg::CODE_RIGHT_QUOTE) ?
		gtp_pkg::CODE_APOSTROPHE : char_code;
	assign ch_norm = (ch_q1 inside {[gtp_pkg::CODE_LOWER_A:gtp_pkg::CODE_LOWER_Z]}) ?
		ch_q1 - gtp_pkg::CASE_OFFSET : ch_q1;
	assign skipped = (ch_norm == gtp_pkg::CODE_UNDERSCORE) ||
		(ch_norm < gtp_pkg::CODE_SPACE);

	// round an odd column up to even
	assign x_even     = 12'(x_pos) + 12'(x_pos[0]);
	assign right_edge = 13'(x_even) + $signed({8'd0, glyph_width});
	assign off_left   = right_edge <= 13'sd0;

	assign push = accept && !clipped && !skipped && !off_left;

	always_comb begin
		entry.half     = half_line_mode;
		entry.wide     = glyph_width > gtp_pkg::NARROW_WIDTH;
		entry.col      = x_even[11:3];
		entry.sub      = x_even[2:0];
		entry.row_prod = 13'(y_pos[9:3]) * 13'(row_stride);
		entry.idx      = ch_norm - gtp_pkg::CODE_SPACE;
	end

endmodule

// ----- hw/rtl/gtp_queue.sv -----
// ----------------------------------------------------------------------------
// gtp_queue
// short fifo between the classifying front and the command back end
// ----------------------------------------------------------------------------
module gtp_queue #(
	parameter int DEPTH = gtp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gtp_pkg::entry_t wr_entry,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output gtp_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gtp_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/gtp_back.sv -----
// ----------------------------------------------------------------------------
// gtp_back
// steps through the tile commands of the head entry into the output register
// ----------------------------------------------------------------------------
module gtp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  gtp_pkg::entry_t       head,
	input  logic [31:0]           vram_base,
	input  logic [31:0]           glyph_base,
	input  logic [5:0]            row_stride,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [31:0]           dest_addr,
	output logic [2:0]            sub_x,
	output logic [31:0]           src_addr,
	output logic [4:0]            tile_col,
	output logic                  last,
	output gtp_pkg::back_status_t status
);

	gtp_pkg::cmd_t      step_q;
	logic               valid_q;
	logic               advance;
	logic               right;
	logic               lower;
	logic               is_last;
	logic signed [8:0]  col_c;
	logic signed [14:0] tile_off;
	logic [31:0]        dest_c;
	logic [31:0]        src_c;

	assign right = step_q[1];
	assign lower = step_q[0];

	assign advance = q_valid && (!valid_q || !out_stall);

	always_comb begin
		if (head.half) begin
			is_last = 1'b1;
		end else if (head.wide) begin
			is_last = step_q == gtp_pkg::CMD_LOWER_RIGHT;
		end else begin
			is_last = step_q == gtp_pkg::CMD_LOWER_LEFT;
		end
	end

	// tile offset in units of one 64-byte tile
	assign col_c    = head.col + 9'(right);
	assign tile_off = 15'(col_c) + $signed({2'b00, head.row_prod}) +
		$signed({9'd0, (lower ? row_stride : 6'd0)});
	assign dest_c   = vram_base + {{11{tile_off[14]}}, tile_off, 6'd0};
	assign src_c    = head.half ? glyph_base + {18'd0, head.idx, 6'd0} :
		glyph_base + {16'd0, head.idx, lower, right, 6'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= gtp_pkg::CMD_UPPER_LEFT;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q  <= is_last ? gtp_pkg::CMD_UPPER_LEFT : gtp_pkg::cmd_t'(step_q + 2'd1);
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dest_addr <= dest_c;
			sub_x     <= head.sub;
			src_addr  <= src_c;
			tile_col  <= col_c[4:0];
			last      <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign status.step = step_q;
	assign status.pop  = advance && is_last;

endmodule

// ----- hw/rtl/glyph_tile_placement.sv -----
// ----------------------------------------------------------------------------
// glyph_tile_placement
// turns one character placement into up to four tile blend commands
// ----------------------------------------------------------------------------
// path: the queue registers the entry, then the back end its first command
// throughput: one command per cycle from the back end while out_stall is low,
//   so a character gives 1 command (8x8), 2 (16x16 narrow) or 4 (16x16 wide)
// a two-entry queue lets the front accept while the back end is busy
// reset: asynchronous, control and config registers return to their reset values, queue empties
module glyph_tile_placement #(
	parameter int SCREEN_W = gtp_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = gtp_pkg::SCREEN_H_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic signed [10:0] x_pos,
	input  logic signed [10:0] y_pos,
	input  logic [4:0]         glyph_width,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        dest_addr,
	output logic [2:0]         sub_x,
	output logic [31:0]        src_addr,
	output logic [4:0]         tile_col,
	output logic               last
);

	logic [31:0]           vram_base_q;
	logic [31:0]           glyph_base_q;
	logic [5:0]            row_stride_q;
	logic                  half_line_q;
	logic                  push;
	gtp_pkg::entry_t       wr_entry;
	gtp_pkg::entry_t       head;
	logic                  q_full;
	logic                  q_valid;
	gtp_pkg::back_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vram_base_q  <= 32'd0;
			glyph_base_q <= 32'd0;
			row_stride_q <= 6'd32;
			half_line_q  <= 1'b0;
		end else if (cfg_we) begin
			case (gtp_pkg::cfg_reg_t'(cfg_idx))
				gtp_pkg::REG_VRAM_BASE:  vram_base_q  <= cfg_data;
				gtp_pkg::REG_GLYPH_BASE: glyph_base_q <= cfg_data;
				gtp_pkg::REG_ROW_STRIDE: row_stride_q <= cfg_data[5:0];
				gtp_pkg::REG_HALF_LINE:  half_line_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;

	gtp_front #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_front (
		.accept        (in_valid && !in_stall),
		.char_code     (char_code),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.glyph_width   (glyph_width),
		.row_stride    (row_stride_q),
		.half_line_mode(half_line_q),
		.push          (push),
		.entry         (wr_entry)
	);

	gtp_queue #(
		.DEPTH(gtp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (status.pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (head)
	);

	gtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.vram_base (vram_base_q),
		.glyph_base(glyph_base_q),
		.row_stride(row_stride_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.dest_addr (dest_addr),
		.sub_x     (sub_x),
		.src_addr  (src_addr),
		.tile_col  (tile_col),
		.last      (last),
		.status    (status)
	);

`ifndef ASSERT_OFF
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> q_valid)
		else $error("queue popped while empty");

	a_step_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		(status.step != gtp_pkg::CMD_UPPER_LEFT) |-> (q_valid && !head.half))
		else $error("command step advanced without a 16x16 entry");

	a_full_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("queue full but empty");

	a_right_only_wide: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && status.step[1]) |-> head.wide)
		else $error("right tile command for narrow glyph");
`endif

endmodule
